>>> hw/rtl/tza_pkg.sv
package tza_pkg;

  localparam int MAX_BLOCKS_DEF = 32;
  localparam int HEAP_BYTES     = 65536;
  localparam int HEADER_BYTES   = 16;
  localparam int LINK_W         = 6;
  localparam int MAX_NOTICES    = 32;
  localparam int NOTE_W         = 6;
  localparam logic [7:0] PURGE_RESET = 8'd100;

  localparam logic CFG_PURGE = 1'b0;
  localparam logic CFG_ZONE  = 1'b1;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;
  localparam logic [1:0] OP_CTAG  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_BADADDR = 3'd2;
  localparam logic [2:0] ST_OWNER   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] req_bytes;
    logic [7:0]  tag;
    logic [3:0]  align_bits;
    logic        has_owner;
    logic [15:0] owner_id;
    logic [15:0] address;
    logic [7:0]  low_tag;
    logic [7:0]  high_tag;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [15:0] result_address;
    logic [15:0] released_owner;
    logic [16:0] free_total;
    logic [16:0] purgeable_total;
    logic [16:0] used_total;
    logic        last;
  } res_t;

  typedef struct packed {
    logic              used;
    logic              owned;
    logic [16:0]       start;
    logic [16:0]       size;
    logic [7:0]        tag;
    logic [15:0]       owner;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } entry_t;

  typedef struct packed {
    logic [LINK_W-1:0] addr;
    logic              we;
    entry_t            wdata;
    logic              v_we;
    logic              v_val;
    logic [LINK_W-1:0] v_idx;
  } tbl_cmd_t;

  typedef struct packed {
    entry_t            rdata;
    logic              rvalid;
    logic              free_ok;
    logic [LINK_W-1:0] free_idx;
  } tbl_rsp_t;

endpackage

>>> hw/rtl/tza_if.sv
interface tza_in_if;
  logic          valid;
  logic          ready;
  tza_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tza_out_if;
  logic          valid;
  logic          ready;
  tza_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/tza_table.sv
module tza_table #(
  parameter int MAX_BLOCKS = tza_pkg::MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tza_pkg::tbl_cmd_t cmd,
  input  logic              init,
  input  logic [16:0]       init_size,
  output tza_pkg::tbl_rsp_t rsp
);

  localparam int LW = tza_pkg::LINK_W;
  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [LW-1:0] WALL = LW'(MAX_BLOCKS);

  tza_pkg::entry_t       ent_r [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid_r;
  logic [LW-1:0]         wall_next_r;
  logic [LW-1:0]         wall_prev_r;
  logic                  is_wall;
  tza_pkg::entry_t       init_ent;

  assign is_wall = (cmd.addr == WALL);

  always_comb begin
    init_ent       = '0;
    init_ent.size  = rst_n ? init_size : 17'(tza_pkg::HEAP_BYTES);
    init_ent.next  = WALL;
    init_ent.prev  = WALL;
  end

  always_comb begin
    rsp = '0;
    if (is_wall) begin
      rsp.rdata.used = 1'b1;
      rsp.rdata.next = wall_next_r;
      rsp.rdata.prev = wall_prev_r;
      rsp.rvalid     = 1'b1;
    end else begin
      rsp.rdata  = ent_r[cmd.addr[AW-1:0]];
      rsp.rvalid = valid_r[cmd.addr[AW-1:0]];
    end
    // lowest unused entry
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        rsp.free_ok  = 1'b1;
        rsp.free_idx = LW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      valid_r     <= MAX_BLOCKS'(1);
      wall_next_r <= '0;
      wall_prev_r <= '0;
    end else begin
      if (cmd.v_we) begin
        valid_r[cmd.v_idx[AW-1:0]] <= cmd.v_val;
      end
      if (cmd.we && is_wall) begin
        wall_next_r <= cmd.wdata.next;
        wall_prev_r <= cmd.wdata.prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      ent_r[0] <= init_ent;
    end else if (cmd.we && !is_wall) begin
      ent_r[cmd.addr[AW-1:0]] <= cmd.wdata;
    end
  end

endmodule

>>> hw/rtl/tagged_zone_allocator.sv
// channel | dir | payload                                         | transfer
// in_ch   | in  | op, req_bytes, tag, align_bits, owner, address.. | valid & ready
// out_ch  | out | kind, status, address, owner, totals, last      | valid & ready
// cfg_*   | in  | cfg_index, cfg_data                              | cfg_we
//
// one operation at a time; every step goes through the single block table port,
// one entry per cycle. allocate visits blocks from the rover and may purge some
// on the way, free scans up to MAX_BLOCKS entries, and every operation ends with
// a recount of all MAX_BLOCKS entries, then the results are sent one by one.
// synchronous active-low reset: heap is one free block, purge level 100.
// in_ch.ready is high only between operations; results wait in an output register.
module tagged_zone_allocator #(
  parameter int MAX_BLOCKS = tza_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tza_in_if.sink      in_ch,
  tza_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int LW    = tza_pkg::LINK_W;
  localparam int LIMIT = 4 * (MAX_BLOCKS + 1);
  localparam int GW    = $clog2(LIMIT + 2);
  localparam int KW    = $clog2(MAX_BLOCKS + 2);
  localparam int NIW   = $clog2(tza_pkg::MAX_NOTICES);
  localparam logic [LW-1:0] WALL = LW'(MAX_BLOCKS);
  localparam logic [LW-1:0] LAST_IDX = LW'(MAX_BLOCKS - 1);
  localparam logic [16:0] HD17 = 17'(tza_pkg::HEADER_BYTES);
  localparam logic [18:0] HD19 = 19'(tza_pkg::HEADER_BYTES);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_A0   = 5'd1;
  localparam logic [4:0] S_A1   = 5'd2;
  localparam logic [4:0] S_AL   = 5'd3;
  localparam logic [4:0] S_AC   = 5'd4;
  localparam logic [4:0] S_AP0  = 5'd5;
  localparam logic [4:0] S_AP1  = 5'd6;
  localparam logic [4:0] S_AP2  = 5'd7;
  localparam logic [4:0] S_AG0  = 5'd8;
  localparam logic [4:0] S_AG1  = 5'd9;
  localparam logic [4:0] S_AG2  = 5'd10;
  localparam logic [4:0] S_AG4  = 5'd11;
  localparam logic [4:0] S_SP0  = 5'd12;
  localparam logic [4:0] S_SP1  = 5'd13;
  localparam logic [4:0] S_SP2  = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;
  localparam logic [4:0] S_FU   = 5'd16;
  localparam logic [4:0] S_CT   = 5'd17;
  localparam logic [4:0] S_FR0  = 5'd18;
  localparam logic [4:0] S_FR1  = 5'd19;
  localparam logic [4:0] S_FR2  = 5'd20;
  localparam logic [4:0] S_FR3  = 5'd21;
  localparam logic [4:0] S_R0   = 5'd22;
  localparam logic [4:0] S_R1   = 5'd23;
  localparam logic [4:0] S_R2   = 5'd24;
  localparam logic [4:0] S_R3   = 5'd25;
  localparam logic [4:0] S_R4   = 5'd26;
  localparam logic [4:0] S_R5   = 5'd27;
  localparam logic [4:0] S_RC0  = 5'd28;
  localparam logic [4:0] S_RC   = 5'd29;
  localparam logic [4:0] S_EM   = 5'd30;

  logic [4:0]          state_r;
  logic [4:0]          ret_r;
  tza_pkg::req_t       in_r;
  logic [7:0]          purge_r;
  logic [LW-1:0]       rover_r;
  logic [LW-1:0]       rv_r;
  logic [LW-1:0]       end_r;
  logic [GW-1:0]       guard_r;
  logic [18:0]         data_r;
  logic [LW-1:0]       b_r;
  logic [LW-1:0]       n_r;
  logic [16:0]         diff_r;
  logic [16:0]         nst_r;
  logic [16:0]         sv_size_r;
  logic [LW-1:0]       sv_next_r;
  logic [LW-1:0]       sv_prev_r;
  logic [LW-1:0]       sv_s_r;
  logic                sv_used_r;
  logic [7:0]          sv_tag_r;
  logic [LW-1:0]       cur_r;
  logic [16:0]         cur_size_r;
  logic [LW-1:0]       fr_n_r;
  logic [KW-1:0]       k_r;
  logic [LW-1:0]       idx_r;
  logic [2:0]          status_r;
  logic [15:0]         addr_r;
  logic [16:0]         free_r;
  logic [16:0]         purg_r;
  logic [16:0]         used_r;
  logic [tza_pkg::NOTE_W-1:0] note_n_r;
  logic [tza_pkg::NOTE_W-1:0] emit_k_r;
  logic [15:0]         note_addr_r [tza_pkg::MAX_NOTICES];
  logic [15:0]         note_owner_r [tza_pkg::MAX_NOTICES];
  logic                out_valid_r;
  tza_pkg::res_t       out_r;

  tza_pkg::tbl_cmd_t   cmd;
  tza_pkg::tbl_rsp_t   rsp;
  tza_pkg::entry_t     rd;
  tza_pkg::entry_t     new_ent;
  logic                zone_wr;
  logic [16:0]         zone_clamp;
  logic [16:0]         rnd;
  logic [16:0]         size_q;
  logic [15:0]         mask16;
  logic [18:0]         data_c;
  logic                fit_c;
  logic [16:0]         nstart_c;
  logic [16:0]         diff_c;
  logic [15:0]         payload_c;
  logic                split_c;
  logic                match_c;
  logic                owner_bad;
  logic                out_free;
  logic                push_note;

  assign rd         = rsp.rdata;
  assign zone_wr    = cfg_we && (cfg_index == tza_pkg::CFG_ZONE);
  assign zone_clamp = (cfg_data < 17'd64) ? 17'd64 :
                      (cfg_data > 17'(tza_pkg::HEAP_BYTES)) ? 17'(tza_pkg::HEAP_BYTES) :
                      cfg_data;

  assign rnd       = ({1'b0, in_r.req_bytes} + 17'd3) & ~17'd3;
  assign size_q    = rnd + HD17;
  assign mask16    = 16'((17'd1 << in_r.align_bits) - 17'd1);
  assign data_c    = ({2'b0, rd.start} + HD19 + {3'b0, mask16}) & ~{3'b0, mask16};
  assign fit_c     = ({2'b0, rd.start} + {2'b0, rd.size}) >= (data_c + {2'b0, size_q} - HD19);
  assign nstart_c  = 17'(data_r - HD19);
  assign diff_c    = nstart_c - rd.start;
  assign payload_c = 16'(rd.start + HD17);
  assign split_c   = (rd.size > size_q) && ((rd.size - size_q) > HD17);
  assign match_c   = rsp.rvalid && rd.used && (payload_c == in_r.address);
  assign owner_bad = !in_r.has_owner && (in_r.tag >= purge_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign push_note = (state_r == S_R0) && rd.owned &&
                     (note_n_r < tza_pkg::NOTE_W'(tza_pkg::MAX_NOTICES));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  tza_table #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .init      (zone_wr),
    .init_size (zone_clamp),
    .rsp       (rsp)
  );

  always_comb begin
    new_ent      = '0;
    new_ent.prev = b_r;
    new_ent.next = sv_next_r;
    if (state_r == S_AG1) begin
      new_ent.start = nst_r;
      new_ent.size  = sv_size_r - diff_r;
    end else begin
      new_ent.start = nst_r;
      new_ent.size  = sv_size_r - size_q;
    end
  end

  // table port: the address read in a state is also the one written
  always_comb begin
    cmd       = '0;
    cmd.wdata = rd;
    unique case (state_r)
      S_A0, S_AC, S_AP0, S_AP1, S_AP2: cmd.addr = rover_r;
      S_A1: cmd.addr = sv_prev_r;
      S_AL, S_FR1: cmd.addr = rv_r;
      S_AG0: begin
        cmd.addr = b_r;
        if (diff_c > HD17) begin
          if (rsp.free_ok) begin
            cmd.we         = 1'b1;
            cmd.wdata.size = diff_c;
            cmd.wdata.next = rsp.free_idx;
          end
        end else if (diff_c != 17'd0) begin
          cmd.we          = 1'b1;
          cmd.wdata.start = nstart_c;
          cmd.wdata.size  = rd.size - diff_c;
        end
      end
      S_AG1, S_SP1: begin
        cmd.addr  = n_r;
        cmd.we    = 1'b1;
        cmd.wdata = new_ent;
        cmd.v_we  = 1'b1;
        cmd.v_val = 1'b1;
        cmd.v_idx = n_r;
      end
      S_AG2, S_SP2: begin
        cmd.addr       = sv_next_r;
        cmd.we         = 1'b1;
        cmd.wdata.prev = n_r;
      end
      S_AG4: begin
        // the end wall ignores the size write
        cmd.addr       = sv_prev_r;
        cmd.we         = 1'b1;
        cmd.wdata.size = rd.size + diff_r;
      end
      S_SP0: begin
        cmd.addr = b_r;
        if (split_c && rsp.free_ok) begin
          cmd.we         = 1'b1;
          cmd.wdata.size = size_q;
          cmd.wdata.next = rsp.free_idx;
        end
      end
      S_FIN: begin
        cmd.addr        = b_r;
        cmd.we          = 1'b1;
        cmd.wdata.used  = 1'b1;
        cmd.wdata.owned = in_r.has_owner;
        cmd.wdata.owner = in_r.has_owner ? in_r.owner_id : 16'd0;
        cmd.wdata.tag   = in_r.tag;
      end
      S_FU, S_RC: cmd.addr = idx_r;
      S_CT: begin
        cmd.addr = sv_s_r;
        if (!((in_r.tag >= purge_r) && !rd.owned)) begin
          cmd.we        = 1'b1;
          cmd.wdata.tag = in_r.tag;
        end
      end
      S_FR0: cmd.addr = WALL;
      S_FR2: cmd.addr = sv_next_r;
      S_R0: begin
        cmd.addr        = sv_s_r;
        cmd.we          = 1'b1;
        cmd.wdata.used  = 1'b0;
        cmd.wdata.owned = 1'b0;
        cmd.wdata.tag   = 8'd0;
        cmd.wdata.owner = 16'd0;
      end
      S_R1: begin
        cmd.addr = sv_prev_r;
        if (!rd.used) begin
          cmd.we         = 1'b1;
          cmd.wdata.size = rd.size + sv_size_r;
          cmd.wdata.next = sv_next_r;
          cmd.v_we       = 1'b1;
          cmd.v_idx      = sv_s_r;
        end
      end
      S_R2: begin
        cmd.addr       = sv_next_r;
        cmd.we         = 1'b1;
        cmd.wdata.prev = cur_r;
      end
      S_R3: begin
        cmd.addr = sv_next_r;
        if (!rd.used) begin
          cmd.v_we  = 1'b1;
          cmd.v_idx = sv_next_r;
        end
      end
      S_R4: begin
        cmd.addr       = cur_r;
        cmd.we         = 1'b1;
        cmd.wdata.size = cur_size_r + sv_size_r;
        cmd.wdata.next = sv_prev_r;
      end
      S_R5: begin
        cmd.addr       = sv_prev_r;
        cmd.we         = 1'b1;
        cmd.wdata.prev = cur_r;
      end
      default: cmd.addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_note) begin
      note_addr_r[note_n_r[NIW-1:0]]  <= payload_c;
      note_owner_r[note_n_r[NIW-1:0]] <= rd.owner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      purge_r     <= tza_pkg::PURGE_RESET;
      rover_r     <= '0;
      free_r      <= 17'(tza_pkg::HEAP_BYTES);
      purg_r      <= '0;
      used_r      <= '0;
      note_n_r    <= '0;
      emit_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // while emitting, the emit state owns the valid flag
      if (out_ch.ready && (state_r != S_EM)) begin
        out_valid_r <= 1'b0;
      end
      if (push_note) begin
        note_n_r <= note_n_r + 1'b1;
      end
      if (cfg_we && (cfg_index == tza_pkg::CFG_PURGE)) begin
        purge_r <= cfg_data[7:0];
      end
      if (zone_wr) begin
        rover_r <= '0;
        free_r  <= zone_clamp;
        purg_r  <= '0;
        used_r  <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            in_r     <= in_ch.data;
            note_n_r <= '0;
            status_r <= tza_pkg::ST_OK;
            addr_r   <= '0;
            idx_r    <= '0;
            unique case (in_ch.data.op)
              tza_pkg::OP_ALLOC: state_r <= S_A0;
              tza_pkg::OP_RANGE: state_r <= S_FR0;
              default:           state_r <= S_FU;
            endcase
          end
        end
        S_A0: begin
          if (owner_bad) begin
            status_r <= tza_pkg::ST_OWNER;
            state_r  <= S_RC0;
          end else begin
            sv_prev_r <= rd.prev;
            state_r   <= S_A1;
          end
        end
        S_A1: begin
          // step back onto a free block in front of the rover
          if (!rd.used) begin
            rover_r <= sv_prev_r;
            end_r   <= rd.prev;
            rv_r    <= sv_prev_r;
          end else begin
            end_r <= sv_prev_r;
            rv_r  <= rover_r;
          end
          guard_r <= '0;
          state_r <= S_AL;
        end
        S_AL: begin
          if ((rv_r == end_r) || (guard_r > GW'(LIMIT))) begin
            status_r <= tza_pkg::ST_NOSPACE;
            state_r  <= S_RC0;
          end else if (rd.used) begin
            if ((rv_r == WALL) || (rd.tag < purge_r)) begin
              rover_r <= rd.next;
              rv_r    <= rd.next;
              state_r <= S_AC;
            end else begin
              state_r <= S_AP0;
            end
          end else begin
            rv_r    <= rd.next;
            state_r <= S_AC;
          end
        end
        S_AP0: begin
          rover_r <= rd.prev;
          sv_s_r  <= rv_r;
          ret_r   <= S_AP1;
          state_r <= S_R0;
        end
        S_AP1: begin
          rover_r <= rd.next;
          state_r <= S_AP2;
        end
        S_AP2: begin
          rv_r    <= rd.next;
          state_r <= S_AC;
        end
        S_AC: begin
          if (!rd.used && fit_c) begin
            data_r  <= data_c;
            b_r     <= rover_r;
            state_r <= (in_r.align_bits != 4'd0) ? S_AG0 : S_SP0;
          end else begin
            guard_r <= guard_r + 1'b1;
            state_r <= S_AL;
          end
        end
        S_AG0: begin
          nst_r  <= nstart_c;
          diff_r <= diff_c;
          if (diff_c > HD17) begin
            if (!rsp.free_ok) begin
              status_r <= tza_pkg::ST_FULL;
              state_r  <= S_RC0;
            end else begin
              n_r       <= rsp.free_idx;
              sv_size_r <= rd.size;
              sv_next_r <= rd.next;
              state_r   <= S_AG1;
            end
          end else if (diff_c != 17'd0) begin
            sv_prev_r <= rd.prev;
            state_r   <= S_AG4;
          end else begin
            state_r <= S_SP0;
          end
        end
        S_AG1: state_r <= S_AG2;
        S_AG2: begin
          b_r     <= n_r;
          state_r <= S_SP0;
        end
        S_AG4: state_r <= S_SP0;
        S_SP0: begin
          if (split_c && rsp.free_ok) begin
            n_r       <= rsp.free_idx;
            sv_size_r <= rd.size;
            sv_next_r <= rd.next;
            nst_r     <= rd.start + size_q;
            state_r   <= S_SP1;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_SP1: state_r <= S_SP2;
        S_SP2: state_r <= S_FIN;
        S_FIN: begin
          addr_r  <= payload_c;
          rover_r <= rd.next;
          state_r <= S_RC0;
        end
        S_FU: begin
          if (match_c) begin
            sv_s_r <= idx_r;
            ret_r  <= S_RC0;
            state_r <= (in_r.op == tza_pkg::OP_FREE) ? S_R0 : S_CT;
          end else if (idx_r == LAST_IDX) begin
            status_r <= tza_pkg::ST_BADADDR;
            state_r  <= S_RC0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_CT: begin
          if ((in_r.tag >= purge_r) && !rd.owned) begin
            status_r <= tza_pkg::ST_OWNER;
          end
          state_r <= S_RC0;
        end
        S_FR0: begin
          rv_r    <= rd.next;
          k_r     <= '0;
          state_r <= S_FR1;
        end
        S_FR1: begin
          if ((k_r >= KW'(MAX_BLOCKS + 1)) || (rv_r == WALL)) begin
            state_r <= S_RC0;
          end else begin
            sv_next_r <= rd.next;
            sv_used_r <= rd.used;
            sv_tag_r  <= rd.tag;
            state_r   <= S_FR2;
          end
        end
        S_FR2: begin
          // skip a free successor, it may merge away during the release
          fr_n_r <= rd.used ? sv_next_r : rd.next;
          if (sv_used_r && (sv_tag_r >= in_r.low_tag) && (sv_tag_r <= in_r.high_tag)) begin
            sv_s_r  <= rv_r;
            ret_r   <= S_FR3;
            state_r <= S_R0;
          end else begin
            state_r <= S_FR3;
          end
        end
        S_FR3: begin
          rv_r    <= fr_n_r;
          k_r     <= k_r + 1'b1;
          state_r <= S_FR1;
        end
        S_R0: begin
          sv_size_r <= rd.size;
          sv_next_r <= rd.next;
          sv_prev_r <= rd.prev;
          state_r   <= S_R1;
        end
        S_R1: begin
          if (!rd.used) begin
            if (sv_s_r == rover_r) begin
              rover_r <= sv_prev_r;
            end
            cur_r      <= sv_prev_r;
            cur_size_r <= rd.size + sv_size_r;
            state_r    <= S_R2;
          end else begin
            cur_r      <= sv_s_r;
            cur_size_r <= sv_size_r;
            state_r    <= S_R3;
          end
        end
        S_R2: state_r <= S_R3;
        S_R3: begin
          if (!rd.used) begin
            if (sv_next_r == rover_r) begin
              rover_r <= cur_r;
            end
            sv_size_r <= rd.size;
            sv_prev_r <= rd.next;
            state_r   <= S_R4;
          end else begin
            state_r <= ret_r;
          end
        end
        S_R4: state_r <= S_R5;
        S_R5: state_r <= ret_r;
        S_RC0: begin
          free_r  <= '0;
          purg_r  <= '0;
          used_r  <= '0;
          idx_r   <= '0;
          state_r <= S_RC;
        end
        S_RC: begin
          if (rsp.rvalid) begin
            if (!rd.used) begin
              free_r <= free_r + rd.size;
            end else if (rd.tag >= purge_r) begin
              purg_r <= purg_r + rd.size;
            end else begin
              used_r <= used_r + rd.size;
            end
          end
          if (idx_r == LAST_IDX) begin
            emit_k_r <= '0;
            state_r  <= S_EM;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EM: begin
          if (out_free) begin
            out_valid_r           <= 1'b1;
            out_r.free_total      <= free_r;
            out_r.purgeable_total <= purg_r;
            out_r.used_total      <= used_r;
            if (emit_k_r < note_n_r) begin
              out_r.kind           <= tza_pkg::KIND_NOTICE;
              out_r.status         <= tza_pkg::ST_OK;
              out_r.result_address <= note_addr_r[emit_k_r[NIW-1:0]];
              out_r.released_owner <= note_owner_r[emit_k_r[NIW-1:0]];
              out_r.last           <= 1'b0;
              emit_k_r             <= emit_k_r + 1'b1;
            end else begin
              out_r.kind           <= tza_pkg::KIND_STATUS;
              out_r.status         <= status_r;
              out_r.result_address <= (status_r == tza_pkg::ST_OK) ? addr_r : 16'd0;
              out_r.released_owner <= 16'd0;
              out_r.last           <= 1'b1;
              state_r              <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
